// ----- src/multivoice_wavetable_level_modulator_macros.svh -----
// assertion macros for the multivoice wavetable level modulator
// depends on signals clk and rst_n in the module that includes it
`ifndef MULTIVOICE_WAVETABLE_LEVEL_MODULATOR_MACROS_SVH
`define MULTIVOICE_WAVETABLE_LEVEL_MODULATOR_MACROS_SVH

// condition holds at every edge outside reset
`define MWLM_ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define MWLM_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define MWLM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/mwlm_pkg.sv -----
// shared types, constants and waveform functions of the level modulator
// no dependencies
package mwlm_pkg;

  // voice and field geometry
  localparam int VOICE_COUNT = 9;
  localparam int VOICE_W     = 4;
  localparam int TABLE_LEN   = 16;
  localparam int IDX_W       = 4;
  localparam int LEVEL_W     = 4;
  localparam int PERIOD_W    = 12;
  localparam int PHASE_W     = 16;
  localparam int CHIP_W      = 2;
  localparam int DETUNE_W    = 8;
  localparam int PW_W        = 5;
  localparam int SHAPE_W     = 2;
  localparam int PROD_W      = 2 * LEVEL_W;

  // step division geometry
  localparam int STEP_NUM = 23040 * TABLE_LEN;
  localparam int DIV_BITS = $clog2(STEP_NUM + 1);
  localparam int DVSR_W   = 13;
  localparam int ADJ_W    = DVSR_W + 1;
  localparam int CNT_W    = $clog2(DIV_BITS + 1);

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_SHAPE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DETUNE      = 2'd2;

  // waveform codes
  localparam logic [SHAPE_W-1:0] WAVE_SQUARE = 2'd0;
  localparam logic [SHAPE_W-1:0] WAVE_SAW    = 2'd1;
  localparam logic [SHAPE_W-1:0] WAVE_TRI    = 2'd2;
  localparam logic [SHAPE_W-1:0] WAVE_PULSE  = 2'd3;

  localparam logic [CHIP_W-1:0] CHIP_NONE = 2'd3;
  localparam logic [LEVEL_W-1:0] FULL_SCALE = 4'hF;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_ON    = 2'd1,
    ACT_OFF   = 2'd2,
    ACT_LEVEL = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  // triangle samples, rising then falling
  localparam logic [LEVEL_W-1:0] TRI_TABLE [TABLE_LEN] = '{
    4'd0, 4'd1, 4'd3, 4'd5, 4'd7, 4'd9, 4'd11, 4'd13,
    4'd15, 4'd14, 4'd12, 4'd10, 4'd8, 4'd6, 4'd4, 4'd2
  };

  function automatic logic [LEVEL_W-1:0] wave_sample(
    input logic [SHAPE_W-1:0] shape,
    input logic [PW_W-1:0]    pw,
    input logic [IDX_W-1:0]   i
  );
    logic [IDX_W-1:0]   hs;
    logic [LEVEL_W-1:0] res;
    // duty clamped to 1..15
    if (pw == '0) begin
      hs = IDX_W'(1);
    end else if (pw > PW_W'(TABLE_LEN - 1)) begin
      hs = IDX_W'(TABLE_LEN - 1);
    end else begin
      hs = pw[IDX_W-1:0];
    end
    case (shape)
      WAVE_SQUARE: res = (i < hs) ? FULL_SCALE : '0;
      WAVE_SAW:    res = FULL_SCALE - i;
      WAVE_TRI:    res = TRI_TABLE[i];
      default:     res = (i == '0) ? FULL_SCALE : '0;
    endcase
    return res;
  endfunction

  // chip of a slot, three channels per chip
  function automatic logic [CHIP_W-1:0] chip_of(input logic [VOICE_W-1:0] s);
    logic [CHIP_W-1:0] c;
    if (s < VOICE_W'(3)) begin
      c = 2'd0;
    end else if (s < VOICE_W'(6)) begin
      c = 2'd1;
    end else begin
      c = 2'd2;
    end
    return c;
  endfunction

  function automatic logic [CHIP_W-1:0] chan_of(input logic [VOICE_W-1:0] s);
    logic [VOICE_W-1:0] base;
    logic [VOICE_W-1:0] diff;
    base = VOICE_W'(3) * VOICE_W'(chip_of(s));
    diff = s - base;
    return diff[CHIP_W-1:0];
  endfunction

endpackage

// ----- src/mwlm_if.sv -----
// valid/ready channel interfaces for the level modulator input and result words
// depends on mwlm_pkg
interface mwlm_in_if import mwlm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic [VOICE_W-1:0]  voice_index;
  logic [PERIOD_W-1:0] tone_period;
  logic [LEVEL_W-1:0]  target_level;
  logic                bus_busy;

  modport source (output valid, action, voice_index, tone_period, target_level, bus_busy,
                  input ready);
  modport sink (input valid, action, voice_index, tone_period, target_level, bus_busy,
                output ready);
endinterface

interface mwlm_out_if import mwlm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CHIP_W-1:0]  chip_number;
  logic [CHIP_W-1:0]  channel_number;
  logic [LEVEL_W-1:0] level_out;
  logic               reselect;

  modport source (output valid, chip_number, channel_number, level_out, reselect,
                  input ready);
  modport sink (input valid, chip_number, channel_number, level_out, reselect,
                output ready);
endinterface

// ----- src/mwlm_divider.sv -----
// bit-serial restoring divider for the phase step, one quotient bit per cycle
// depends on mwlm_pkg
module mwlm_divider import mwlm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DVSR_W-1:0] divisor,
  output logic              done,
  output logic [PHASE_W-1:0] quotient
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIV_BITS-1:0] num_r, num_nxt;
  logic [DVSR_W-1:0] rem_r, rem_nxt;
  logic [DVSR_W-1:0] dvsr_r, dvsr_nxt;
  logic [PHASE_W-1:0] quo_r, quo_nxt;
  logic [DVSR_W:0]   trial;
  logic [DVSR_W:0]   diff;
  logic              ge;

  // one trial subtraction per cycle
  assign trial = {rem_r, num_r[DIV_BITS-1]};
  assign ge    = trial >= {1'b0, dvsr_r};
  assign diff  = trial - {1'b0, dvsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    dvsr_nxt = dvsr_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = DIV_BITS'(STEP_NUM);
      rem_nxt  = '0;
      dvsr_nxt = divisor;
    end else if (busy_r) begin
      num_nxt = {num_r[DIV_BITS-2:0], 1'b0};
      rem_nxt = ge ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
      quo_nxt = {quo_r[PHASE_W-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIV_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    dvsr_r <= dvsr_nxt;
    quo_r  <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- src/multivoice_wavetable_level_modulator.sv -----
// nine-voice wavetable level modulator: a tick word emits one channel level when its slot
// is enabled and the bus is not busy; every word passes the exec state; an emitting tick then
// passes emit to load the result; a voice-on with nonzero period waits on the 19-step divider
// a word is taken while a result waits; an emitting tick then holds until that result drains
// reset: synchronous active-low rst_n; clears voice enables, slot, last chip and registers
// depends on mwlm_pkg, mwlm_if, mwlm_divider and the macros header
module multivoice_wavetable_level_modulator import mwlm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  mwlm_in_if.sink               in_ch,
  mwlm_out_if.source            out_ch
);

  state_t state_r, state_nxt;

  // configuration registers
  logic [SHAPE_W-1:0]         wave_shape_r;
  logic [PW_W-1:0]            pulse_width_r;
  logic signed [DETUNE_W-1:0] detune_r;

  // latched input word
  action_t             act_r;
  logic [VOICE_W-1:0]  vi_r;
  logic [PERIOD_W-1:0] period_r;
  logic [LEVEL_W-1:0]  lvl_in_r;
  logic                busy_in_r;

  // per-voice storage; enable acts as the valid bit of the other arrays
  logic [PHASE_W-1:0] phase_r [VOICE_COUNT];
  logic [PHASE_W-1:0] step_r  [VOICE_COUNT];
  logic [LEVEL_W-1:0] level_r [VOICE_COUNT];
  logic [VOICE_COUNT-1:0] enabled_r;

  logic [VOICE_W-1:0] slot_r, slot_nxt;
  logic [CHIP_W-1:0]  last_chip_r, last_chip_nxt;

  // emit pipeline and output register
  logic [PROD_W-1:0]  prod_r;
  logic [CHIP_W-1:0]  chip_r, chan_r;
  logic               resel_r;
  logic               out_valid_r, out_valid_nxt;
  logic [CHIP_W-1:0]  out_chip_r, out_chan_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic               out_resel_r;

  logic               in_fire;
  logic               voice_ok;
  logic               slot_en;
  logic [PHASE_W-1:0] phase_new;
  logic [LEVEL_W-1:0] sample;
  logic [VOICE_W-1:0] slot_adv;
  logic signed [ADJ_W-1:0] adj;
  logic [DVSR_W-1:0]  dvsr;
  logic               div_start;
  logic               div_done;
  logic [PHASE_W-1:0] div_quo;
  logic               tick_hit;
  logic               tick_skip;
  logic               emit_load;
  logic [PROD_W:0]    round_sum;
  logic [PROD_W+4:0]  recip;
  logic               wr_on;
  logic [PHASE_W-1:0] wr_step;
  logic               wr_off;
  logic               wr_level;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign voice_ok = vi_r < VOICE_W'(VOICE_COUNT);

  // slot read path
  assign slot_en   = enabled_r[slot_r];
  assign phase_new = phase_r[slot_r] + step_r[slot_r];
  assign sample    = wave_sample(wave_shape_r, pulse_width_r, phase_new[11:8]);
  assign slot_adv  = (slot_r == VOICE_W'(VOICE_COUNT - 1)) ? '0 : slot_r + VOICE_W'(1);

  // adjusted period clamped to at least one
  assign adj  = $signed({2'b00, period_r}) + ADJ_W'(detune_r);
  assign dvsr = (adj < ADJ_W'(1)) ? DVSR_W'(1) : adj[DVSR_W-1:0];

  // (x + 7) / 15 as ((x + 8) * 17) >> 8, exact for x up to 225
  assign round_sum = {1'b0, prod_r} + (PROD_W + 1)'(8);
  assign recip     = {round_sum, 4'b0000} + (PROD_W + 5)'(round_sum);

  assign tick_hit  = (state_r == S_EXEC) && (act_r == ACT_TICK) && !busy_in_r && slot_en;
  assign tick_skip = (state_r == S_EXEC) && (act_r == ACT_TICK) && !busy_in_r && !slot_en;
  assign emit_load = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);
  assign div_start = (state_r == S_EXEC) && (act_r == ACT_ON) && voice_ok
                     && (period_r != '0);

  // voice array writes
  always_comb begin
    wr_on    = 1'b0;
    wr_step  = '0;
    wr_off   = 1'b0;
    wr_level = 1'b0;
    if (state_r == S_EXEC && voice_ok) begin
      case (act_r)
        ACT_ON: begin
          wr_on = (period_r == '0);
        end
        ACT_OFF: begin
          wr_off = 1'b1;
        end
        ACT_LEVEL: begin
          wr_level = 1'b1;
        end
        default: begin
          wr_on = 1'b0;
        end
      endcase
    end else if (state_r == S_DIV && div_done) begin
      wr_on   = 1'b1;
      wr_step = div_quo;
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    last_chip_nxt = last_chip_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        if (tick_hit) begin
          state_nxt     = S_EMIT;
          slot_nxt      = slot_adv;
          last_chip_nxt = chip_of(slot_r);
        end else if (tick_skip) begin
          slot_nxt = slot_adv;
        end else if (div_start) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) state_nxt = S_IDLE;
      end
      S_EMIT: begin
        if (emit_load) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output valid tracking
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      slot_r        <= '0;
      last_chip_r   <= CHIP_NONE;
      out_valid_r   <= 1'b0;
      enabled_r     <= '0;
      wave_shape_r  <= WAVE_SQUARE;
      pulse_width_r <= PW_W'(8);
      detune_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      last_chip_r <= last_chip_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_on) enabled_r[vi_r] <= 1'b1;
      if (wr_off) enabled_r[vi_r] <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_WAVE_SHAPE:  wave_shape_r  <= cfg_wdata[SHAPE_W-1:0];
          REG_PULSE_WIDTH: pulse_width_r <= cfg_wdata[PW_W-1:0];
          REG_DETUNE:      detune_r      <= $signed(cfg_wdata[DETUNE_W-1:0]);
          default: begin
            detune_r <= detune_r;
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r     <= action_t'(in_ch.action);
      vi_r      <= in_ch.voice_index;
      period_r  <= in_ch.tone_period;
      lvl_in_r  <= in_ch.target_level;
      busy_in_r <= in_ch.bus_busy;
    end
    if (wr_on) begin
      step_r[vi_r]  <= wr_step;
      phase_r[vi_r] <= '0;
      level_r[vi_r] <= lvl_in_r;
    end
    if (wr_level) level_r[vi_r] <= lvl_in_r;
    if (tick_hit) begin
      phase_r[slot_r] <= phase_new;
      prod_r  <= sample * level_r[slot_r];
      chip_r  <= chip_of(slot_r);
      chan_r  <= chan_of(slot_r);
      resel_r <= chip_of(slot_r) != last_chip_r;
    end
    if (emit_load) begin
      out_chip_r  <= chip_r;
      out_chan_r  <= chan_r;
      out_level_r <= recip[PROD_W+3:PROD_W];
      out_resel_r <= resel_r;
    end
  end

  mwlm_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (dvsr),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_ch.valid          = out_valid_r;
  assign out_ch.chip_number    = out_chip_r;
  assign out_ch.channel_number = out_chan_r;
  assign out_ch.level_out      = out_level_r;
  assign out_ch.reselect       = out_resel_r;

  // checks
  `include "multivoice_wavetable_level_modulator_macros.svh"

  `MWLM_ASSERT_ALWAYS(a_slot_range, slot_r < VOICE_W'(VOICE_COUNT), "slot out of range")
  `MWLM_ASSERT_IMPL(a_div_done_state, div_done, state_r == S_DIV, "divider done outside DIV")
  `MWLM_ASSERT_NEXT(a_accept_exec, in_fire, state_r == S_EXEC, "accepted word not executed")
  `MWLM_ASSERT_IMPL(a_out_from_emit, $rose(out_valid_r), $past(state_r) == S_EMIT, "result without emit")

endmodule

// ----- tb/sv/tb_multivoice_wavetable_level_modulator.sv -----
`timescale 1ns / 1ps
// testbench for the multivoice wavetable level modulator: directed and random words,
// checked against a voice-level predictor held in a small scoreboard class
// depends on mwlm_pkg, mwlm_if and the multivoice_wavetable_level_modulator rtl

module tb_multivoice_wavetable_level_modulator import mwlm_pkg::*; ();

  // one input word as driven on the input channel
  typedef struct {
    action_t             act;
    logic [VOICE_W-1:0]  voice;
    logic [PERIOD_W-1:0] period;
    logic [LEVEL_W-1:0]  lvl;
    logic                busy;
  } in_word_t;

  // one channel level write as seen on the result channel
  typedef struct packed {
    logic [CHIP_W-1:0]  chip;
    logic [CHIP_W-1:0]  chan;
    logic [LEVEL_W-1:0] level;
    logic               resel;
  } level_word_t;

  localparam int STEP_DIVIDEND = 23040 * 16;

  class level_scoreboard;
    logic [PHASE_W-1:0] phase_acc [VOICE_COUNT];
    logic [PHASE_W-1:0] phase_inc [VOICE_COUNT];
    logic [LEVEL_W-1:0] voice_vol [VOICE_COUNT];
    bit                 voice_on  [VOICE_COUNT];
    int                 next_slot;
    logic [CHIP_W-1:0]  last_chip;
    logic [SHAPE_W-1:0] shape;
    logic [PW_W-1:0]    duty;
    byte                detune;
    level_word_t        pending_levels [$];
    int                 errors;
    int                 checked;
    int                 words;
    int                 ticks;
    int                 voice_ons;

    function new();
      for (int v = 0; v < VOICE_COUNT; v++) begin
        phase_acc[v] = '0;
        phase_inc[v] = '0;
        voice_vol[v] = '0;
        voice_on[v]  = 1'b0;
      end
      next_slot = 0;
      last_chip = CHIP_NONE;
      shape     = WAVE_SQUARE;
      duty      = PW_W'(8);
      detune    = 0;
      errors    = 0;
      checked   = 0;
      words     = 0;
      ticks     = 0;
      voice_ons = 0;
    endfunction

    function int pending();
      return pending_levels.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_WAVE_SHAPE:  shape  = data[SHAPE_W-1:0];
        REG_PULSE_WIDTH: duty   = data[PW_W-1:0];
        REG_DETUNE:      detune = data;
        default: ;
      endcase
    endfunction

    // phase increment of a tone period, clamped divisor, low 16 bits kept
    function logic [PHASE_W-1:0] step_for_period(logic [PERIOD_W-1:0] period);
      int adj;
      if (period == '0) return '0;
      adj = int'(period) + int'(detune);
      if (adj < 1) adj = 1;
      return PHASE_W'(STEP_DIVIDEND / adj);
    endfunction

    // waveform value at table index under the current registers
    function int sample_at(int idx);
      int hs;
      case (shape)
        WAVE_SQUARE: begin
          hs = int'(duty);
          if (hs < 1) hs = 1;
          if (hs > 15) hs = 15;
          return (idx < hs) ? 15 : 0;
        end
        WAVE_SAW: return 15 - idx;
        WAVE_TRI: return (idx < 8) ? (idx * 15) / 8 : 15 - ((idx - 8) * 15) / 8;
        default:  return (idx == 0) ? 15 : 0;
      endcase
    endfunction

    // apply one accepted word and queue the level write it causes
    function void note_word(in_word_t w);
      int          s;
      int          idx;
      level_word_t r;
      words++;
      if (w.act == ACT_TICK) begin
        ticks++;
        if (w.busy) return;
        s = next_slot;
        if (s >= VOICE_COUNT) s = 0;
        if (voice_on[s]) begin
          r.chip       = CHIP_W'(s / 3);
          r.chan       = CHIP_W'(s % 3);
          r.resel      = (r.chip != last_chip);
          last_chip    = r.chip;
          phase_acc[s] = phase_acc[s] + phase_inc[s];
          idx          = int'(phase_acc[s][11:8]);
          r.level      = LEVEL_W'((sample_at(idx) * int'(voice_vol[s]) + 7) / 15);
          pending_levels.push_back(r);
        end
        next_slot = (s + 1) % VOICE_COUNT;
      end else if (w.voice < VOICE_COUNT) begin
        case (w.act)
          ACT_ON: begin
            phase_inc[w.voice] = step_for_period(w.period);
            voice_vol[w.voice] = w.lvl;
            voice_on[w.voice]  = 1'b1;
            phase_acc[w.voice] = '0;
            voice_ons++;
          end
          ACT_OFF: voice_on[w.voice] = 1'b0;
          default: voice_vol[w.voice] = w.lvl;
        endcase
      end
    endfunction

    function void report(string field, int want, int got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    // compare one level write with the oldest expectation
    function void check_word(level_word_t got);
      level_word_t want;
      checked++;
      if (pending_levels.size() == 0) begin
        errors++;
        $display("%0t: unexpected level word, expected none, got chip %0d chan %0d level %0d",
                 $time, got.chip, got.chan, got.level);
        return;
      end
      want = pending_levels.pop_front();
      if (got.chip != want.chip) report("chip_number", want.chip, got.chip);
      if (got.chan != want.chan) report("channel_number", want.chan, got.chan);
      if (got.level != want.level) report("level_out", want.level, got.level);
      if (got.resel != want.resel) report("reselect", want.resel, got.resel);
    endfunction
  endclass

  localparam int RANDOM_WORDS   = 950;
  localparam int PHASES         = 9;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int QUIET_CYCLES   = 40;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mwlm_in_if  in_ch ();
  mwlm_out_if out_ch ();

  level_scoreboard sb;
  in_word_t        seen_in;
  level_word_t     seen_out;
  int              burst_left = 0;
  int              settings = 0;
  int              idle_cycles = 0;

  multivoice_wavetable_level_modulator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // note every accepted input word
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seen_in.act    = action_t'(in_ch.action);
      seen_in.voice  = in_ch.voice_index;
      seen_in.period = in_ch.tone_period;
      seen_in.lvl    = in_ch.target_level;
      seen_in.busy   = in_ch.bus_busy;
      sb.note_word(seen_in);
    end
  end

  // check every accepted result word
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_out.chip  = out_ch.chip_number;
      seen_out.chan  = out_ch.channel_number;
      seen_out.level = out_ch.level_out;
      seen_out.resel = out_ch.reselect;
      sb.check_word(seen_out);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // result side stalls, in one of four ready patterns chosen at random
  initial begin : out_pacing
    int cyc;
    int mode;
    cyc = 0;
    mode = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 128 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= 1'($urandom_range(0, 1));
        2:       out_ch.ready <= (cyc % 8 == 0);
        default: out_ch.ready <= (cyc % 4 != 0);
      endcase
    end
  end

  function automatic in_word_t make_word(action_t act, int voice, int period, int lvl,
                                         bit busy);
    in_word_t w;
    w.act    = act;
    w.voice  = VOICE_W'(voice);
    w.period = PERIOD_W'(period);
    w.lvl    = LEVEL_W'(lvl);
    w.busy   = busy;
    return w;
  endfunction

  // mostly ticks and voice changes on real voices, some stray voices and busy ticks
  function automatic in_word_t random_word();
    in_word_t w;
    int       r;
    int       pm;
    r = $urandom_range(0, 99);
    if (r < 58) w.act = ACT_TICK;
    else if (r < 72) w.act = ACT_ON;
    else if (r < 80) w.act = ACT_OFF;
    else w.act = ACT_LEVEL;
    if ($urandom_range(0, 9) == 0) w.voice = VOICE_W'($urandom_range(VOICE_COUNT, 15));
    else w.voice = VOICE_W'($urandom_range(0, VOICE_COUNT - 1));
    pm = $urandom_range(0, 11);
    if (pm < 2) w.period = '0;
    else if (pm < 6) w.period = PERIOD_W'($urandom_range(1, 40));
    else if (pm == 6) w.period = {PERIOD_W{1'b1}};
    else w.period = PERIOD_W'($urandom);
    w.lvl  = LEVEL_W'($urandom);
    w.busy = ($urandom_range(0, 6) == 0);
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    in_ch.valid        <= 1'b1;
    in_ch.action       <= w.act;
    in_ch.voice_index  <= w.voice;
    in_ch.tone_period  <= w.period;
    in_ch.target_level <= w.lvl;
    in_ch.bus_busy     <= w.busy;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // bursts of random length, random gaps between them, sometimes none
  task automatic send_paced(input in_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    send_word(w);
  endtask

  // hold the sender until every expected level word has come
  task automatic drain(input int extra);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_config(input logic [SHAPE_W-1:0] shape, input logic [PW_W-1:0] pw,
                              input logic [CFG_DATA_W-1:0] det);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WAVE_SHAPE;
    cfg_wdata <= CFG_DATA_W'(shape);
    @(posedge clk);
    cfg_index <= REG_PULSE_WIDTH;
    cfg_wdata <= CFG_DATA_W'(pw);
    @(posedge clk);
    cfg_index <= REG_DETUNE;
    cfg_wdata <= det;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(REG_WAVE_SHAPE, CFG_DATA_W'(shape));
    sb.write_reg(REG_PULSE_WIDTH, CFG_DATA_W'(pw));
    sb.write_reg(REG_DETUNE, det);
    settings++;
  endtask

  initial begin : stimulus
    in_word_t w;
    int       sent;
    sb = new();
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_WAVE_SHAPE;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.action       <= ACT_TICK;
    in_ch.voice_index  <= '0;
    in_ch.tone_period  <= '0;
    in_ch.target_level <= '0;
    in_ch.bus_busy     <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero duty clamps to one high sample
    write_config(WAVE_SQUARE, PW_W'(0), 8'h00);
    send_paced(make_word(ACT_TICK, 0, 0, 0, 1'b0));      // disabled slot, slot still moves
    send_paced(make_word(ACT_ON, 0, 7, 15, 1'b0));
    send_paced(make_word(ACT_ON, 8, 4095, 1, 1'b0));
    send_paced(make_word(ACT_ON, 4, 0, 7, 1'b0));        // zero period, step stays zero
    send_paced(make_word(ACT_ON, 9, 100, 15, 1'b0));     // stray voices do nothing
    send_paced(make_word(ACT_ON, 15, 4095, 15, 1'b1));
    send_paced(make_word(ACT_OFF, 12, 0, 0, 1'b0));
    send_paced(make_word(ACT_LEVEL, 10, 0, 15, 1'b0));
    send_paced(make_word(ACT_TICK, 0, 4095, 15, 1'b1));  // busy bus skips the tick
    // walk every slot and wrap
    for (int i = 0; i < 10; i++) send_paced(make_word(ACT_TICK, 0, 0, 0, 1'b0));
    send_paced(make_word(ACT_LEVEL, 0, 0, 0, 1'b0));
    send_paced(make_word(ACT_OFF, 8, 0, 0, 1'b0));
    send_paced(make_word(ACT_LEVEL, 4, 0, 15, 1'b1));    // non-tick ignores busy
    send_paced(make_word(ACT_ON, 2, 2048, 8, 1'b1));
    for (int i = 0; i < 4; i++) send_paced(make_word(ACT_TICK, 0, 0, 0, 1'b0));

    // random phases, extremes of the registers first
    for (int p = 0; p < PHASES; p++) begin
      drain(QUIET_CYCLES);
      case (p)
        0:       write_config(WAVE_PULSE, PW_W'(16), 8'h80);
        1:       write_config(WAVE_SAW, PW_W'(15), 8'h7F);
        2:       write_config(WAVE_TRI, PW_W'(1), 8'h00);
        3:       write_config(WAVE_SQUARE, PW_W'(16), 8'hFF);
        default: write_config(SHAPE_W'($urandom_range(0, 3)), PW_W'($urandom_range(0, 16)),
                              CFG_DATA_W'($urandom));
      endcase
      sent = 0;
      while (sent < RANDOM_WORDS / PHASES) begin
        w = random_word();
        send_paced(w);
        sent++;
        if ($urandom_range(0, 149) == 0) drain(0);
      end
    end

    drain(QUIET_CYCLES);
    $display("covered %0d input words: %0d ticks, %0d voice-on", sb.words, sb.ticks,
             sb.voice_ons);
    $display("checked %0d level words over %0d register settings, %0d mismatches",
             sb.checked, settings, sb.errors);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
